### design/npz_pkg.sv
`timescale 1ns / 1ps

package npz_pkg;

   localparam int MOMENTUM_BITS = 20;
   localparam int ENERGY_BITS   = MOMENTUM_BITS - 1;
   localparam int W_MASS_BITS   = 16;
   localparam int PZ_BITS       = 24;
   localparam int COUNT_BITS    = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_W_MASS = 1'b0;
   localparam logic [W_MASS_BITS-1:0] W_MASS_RESET = 16'd8040;

   localparam logic [COUNT_BITS-1:0] COUNT_NONE = 2'd0;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE  = 2'd1;
   localparam logic [COUNT_BITS-1:0] COUNT_TWO  = 2'd2;

   localparam int PROD_W   = 2 * MOMENTUM_BITS;
   localparam int WW_W     = 2 * W_MASS_BITS;
   localparam int ALPHA_W  = ((PROD_W > WW_W) ? PROD_W : WW_W) + 2;
   localparam int ALPHA_LO = ALPHA_W / 2;
   localparam int ALPHA_HI = ALPHA_W - ALPHA_LO;
   localparam int A_W      = PROD_W;
   localparam int A_LO     = A_W / 2;
   localparam int A_HI     = A_W - A_LO;
   localparam int B_W      = ALPHA_W + MOMENTUM_BITS;
   localparam int B_LO     = B_W / 2;
   localparam int B_HI     = B_W - B_LO;
   localparam int E2_W     = 2 * ENERGY_BITS;
   localparam int PT2_W    = PROD_W;
   localparam int PT2_LO   = PT2_W / 2;
   localparam int PT2_HI   = PT2_W - PT2_LO;
   localparam int EP_W     = E2_W + PT2_W;
   localparam int ALPHA2_W = 2 * ALPHA_W;
   localparam int C4_W     = ALPHA2_W + 1;
   localparam int C4_LO    = C4_W / 2;
   localparam int C4_HI    = C4_W - C4_LO;
   localparam int BSQ_W    = 2 * B_W;
   localparam int AC_W     = A_W + C4_W;
   localparam int D_W      = ((BSQ_W > AC_W) ? BSQ_W : AC_W) + 1;
   localparam int RAD_W    = D_W + (D_W % 2);
   localparam int R_W      = RAD_W / 2;
   localparam int NB_W     = B_W + 1;
   localparam int N_W      = ((NB_W > R_W + 1) ? NB_W : R_W + 1) + 1;
   localparam int DEN_W    = A_W + 1;
   localparam int Q_W      = PZ_BITS - 1;
   localparam int DIV_W    = (N_W > DEN_W + Q_W) ? N_W : DEN_W + Q_W;

   localparam int FRONT_STAGES = 8;
   localparam int LATENCY      = FRONT_STAGES + R_W + 2 + Q_W + 1;

   localparam logic signed [PZ_BITS-1:0] PZ_MAX = {1'b0, {Q_W{1'b1}}};
   localparam logic signed [PZ_BITS-1:0] PZ_MIN = {1'b1, {Q_W{1'b0}}};

   typedef struct packed {
      logic signed [MOMENTUM_BITS-1:0] lepton_px;
      logic signed [MOMENTUM_BITS-1:0] lepton_py;
      logic signed [MOMENTUM_BITS-1:0] lepton_pz;
      logic [ENERGY_BITS-1:0]          lepton_energy;
      logic signed [MOMENTUM_BITS-1:0] missing_px;
      logic signed [MOMENTUM_BITS-1:0] missing_py;
   } npz_req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]     solution_count;
      logic signed [PZ_BITS-1:0] pz_first;
      logic signed [PZ_BITS-1:0] pz_second;
      logic                      degenerate;
   } npz_rsp_type;

   typedef struct packed {
      logic signed [NB_W-1:0]  nb;
      logic signed [DEN_W-1:0] den;
      logic [COUNT_BITS-1:0]   count;
      logic                    degenerate;
   } npz_mid_type;

endpackage

### design/neutrino_pz_w_mass_solver_top.sv
`timescale 1ns / 1ps

// Solves the W mass constraint quadratic for neutrino pz, one item per clock.
// busy is always low: an item may be started in every cycle, and its result
// appears on rsp_valid/rsp_data after 8 product/sum stages, one stage per square
// root bit, 63, numerator and divider setup, one stage per quotient bit, 23, and
// the output register. The receiver cannot stall; every result shows for one cycle
// only. w_mass is written over APB at addresses 0 to 3 (paddr[2] low); the user
// must write it only while no item is in flight; the block does not enforce this.
module neutrino_pz_w_mass_solver_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  npz_pkg::npz_req_type                req_data,
   output logic                                rsp_valid,
   output npz_pkg::npz_rsp_type                rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [npz_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [npz_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [npz_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import npz_pkg::*;

   localparam logic [RAD_W-1:0] ONE_RAD = RAD_W'(1);

   logic                         csr_hit;
   logic [W_MASS_BITS-1:0]       w_mass_ff;

   logic [7:1]                   vld_ff;

   logic signed [PROD_W-1:0]     s1_xx_in, s1_yy_in, s1_zz_in, s1_mxx_in, s1_myy_in;
   logic [WW_W-1:0]              s1_ww_in;
   logic [E2_W-1:0]              s1_ee_in;
   logic signed [PROD_W-1:0]     s1_xx_ff, s1_yy_ff, s1_zz_ff, s1_mxx_ff, s1_myy_ff;
   logic [WW_W-1:0]              s1_ww_ff;
   logic [E2_W-1:0]              s1_ee_ff;
   logic signed [MOMENTUM_BITS-1:0] s1_lz_ff;

   logic signed [ALPHA_W-1:0]    s2_alpha_in, s2_alpha_ff;
   logic signed [A_W-1:0]        s2_a_in, s2_a_ff;
   logic [PT2_W-1:0]             s2_pt2_in, s2_pt2_ff;
   logic [E2_W-1:0]              s2_e2_ff;
   logic signed [MOMENTUM_BITS-1:0] s2_lz_ff;

   logic signed [ALPHA_LO+MOMENTUM_BITS:0]   s3_blo_in, s3_blo_ff;
   logic signed [ALPHA_HI+MOMENTUM_BITS-1:0] s3_bhi_in, s3_bhi_ff;
   logic signed [2*ALPHA_HI-1:0]             s3_aahh_in, s3_aahh_ff;
   logic signed [ALPHA_HI+ALPHA_LO:0]        s3_aahl_in, s3_aahl_ff;
   logic [2*ALPHA_LO-1:0]                    s3_aall_in, s3_aall_ff;
   logic [E2_W+PT2_LO-1:0]                   s3_eplo_in, s3_eplo_ff;
   logic [E2_W+PT2_HI-1:0]                   s3_ephi_in, s3_ephi_ff;
   logic signed [A_W-1:0]                    s3_a_ff;

   logic signed [B_W-1:0]        s4_b_in, s4_b_ff;
   logic signed [ALPHA2_W-1:0]   s4_al2_in, s4_al2_ff;
   logic [EP_W-1:0]              s4_ep_in, s4_ep_ff;
   logic signed [A_W-1:0]        s4_a_ff;

   logic signed [C4_W-1:0]       s5_c4_in, s5_c4_ff;
   logic signed [B_W-1:0]        s5_b_ff;
   logic signed [A_W-1:0]        s5_a_ff;

   logic signed [2*B_HI-1:0]     s6_bbhh_in, s6_bbhh_ff;
   logic signed [B_HI+B_LO:0]    s6_bbhl_in, s6_bbhl_ff;
   logic [2*B_LO-1:0]            s6_bbll_in, s6_bbll_ff;
   logic signed [A_HI+C4_HI-1:0] s6_achh_in, s6_achh_ff;
   logic signed [A_HI+C4_LO:0]   s6_achl_in, s6_achl_ff;
   logic signed [A_LO+C4_HI:0]   s6_aclh_in, s6_aclh_ff;
   logic [A_LO+C4_LO-1:0]        s6_acll_in, s6_acll_ff;
   logic signed [B_W-1:0]        s6_b_ff;
   logic signed [A_W-1:0]        s6_a_ff;

   logic signed [BSQ_W-1:0]      s7_bsq_in, s7_bsq_ff;
   logic signed [AC_W-1:0]       s7_ac_in, s7_ac_ff;
   logic signed [B_W-1:0]        s7_b_ff;
   logic signed [A_W-1:0]        s7_a_ff;

   logic signed [D_W-1:0]        disc;
   npz_mid_type                  mid_in;

   logic [RAD_W-1:0]             sq_rem_ff  [0:R_W];
   logic [R_W-1:0]               sq_root_ff [0:R_W];
   npz_mid_type                  sq_mid_ff  [0:R_W];
   logic                         sq_vld_ff  [0:R_W];

   logic signed [N_W-1:0]        num_n_in [2];
   logic signed [N_W-1:0]        num_n_ff [2];
   npz_mid_type                  num_mid_ff;
   logic                         num_vld_ff;

   logic [DEN_W-1:0]             den_mag;
   logic [N_W-1:0]               n_mag [2];
   logic [DIV_W-1:0]             dv_rem_ff  [0:Q_W][2];
   logic [Q_W-1:0]               dv_q_ff    [0:Q_W][2];
   logic                         dv_neg_ff  [0:Q_W][2];
   logic                         dv_sat_ff  [0:Q_W][2];
   logic [DEN_W-1:0]             dv_dmag_ff [0:Q_W];
   logic [COUNT_BITS-1:0]        dv_cnt_ff  [0:Q_W];
   logic                         dv_deg_ff  [0:Q_W];
   logic                         dv_vld_ff  [0:Q_W];

   logic signed [PZ_BITS-1:0]    lane_val [2];
   npz_rsp_type                  rsp_in, rsp_data_ff;
   logic                         rsp_valid_ff;

   // configuration
   assign pready  = 1'b1;
   assign busy    = 1'b0;
   assign csr_hit = paddr[CSR_ADDR_W-1] == REG_W_MASS;
   assign prdata  = csr_hit ? CSR_DATA_W'(w_mass_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_mass_ff <= W_MASS_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         w_mass_ff <= pwdata[W_MASS_BITS-1:0];
      end
   end

   // front valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:1], start};
      end
   end

   // stage 1: squares and dot terms
   always_comb begin
      s1_xx_in  = req_data.lepton_px * req_data.missing_px;
      s1_yy_in  = req_data.lepton_py * req_data.missing_py;
      s1_zz_in  = req_data.lepton_pz * req_data.lepton_pz;
      s1_mxx_in = req_data.missing_px * req_data.missing_px;
      s1_myy_in = req_data.missing_py * req_data.missing_py;
      s1_ww_in  = w_mass_ff * w_mass_ff;
      s1_ee_in  = req_data.lepton_energy * req_data.lepton_energy;
   end

   always_ff @(posedge clock) begin
      s1_xx_ff  <= s1_xx_in;
      s1_yy_ff  <= s1_yy_in;
      s1_zz_ff  <= s1_zz_in;
      s1_mxx_ff <= s1_mxx_in;
      s1_myy_ff <= s1_myy_in;
      s1_ww_ff  <= s1_ww_in;
      s1_ee_ff  <= s1_ee_in;
      s1_lz_ff  <= req_data.lepton_pz;
   end

   // stage 2: alpha, a, pt^2
   always_comb begin
      s2_alpha_in = $signed({1'b0, s1_ww_ff}) + ((s1_xx_ff + s1_yy_ff) <<< 1);
      s2_a_in     = s1_zz_ff - $signed({1'b0, s1_ee_ff});
      s2_pt2_in   = $unsigned(s1_mxx_ff) + $unsigned(s1_myy_ff);
   end

   always_ff @(posedge clock) begin
      s2_alpha_ff <= s2_alpha_in;
      s2_a_ff     <= s2_a_in;
      s2_pt2_ff   <= s2_pt2_in;
      s2_e2_ff    <= s1_ee_ff;
      s2_lz_ff    <= s1_lz_ff;
   end

   // stage 3: partial products of b, alpha^2, e^2*pt^2
   always_comb begin
      s3_blo_in  = $signed({1'b0, s2_alpha_ff[ALPHA_LO-1:0]}) * s2_lz_ff;
      s3_bhi_in  = $signed(s2_alpha_ff[ALPHA_W-1:ALPHA_LO]) * s2_lz_ff;
      s3_aahh_in = $signed(s2_alpha_ff[ALPHA_W-1:ALPHA_LO])
                   * $signed(s2_alpha_ff[ALPHA_W-1:ALPHA_LO]);
      s3_aahl_in = $signed(s2_alpha_ff[ALPHA_W-1:ALPHA_LO])
                   * $signed({1'b0, s2_alpha_ff[ALPHA_LO-1:0]});
      s3_aall_in = s2_alpha_ff[ALPHA_LO-1:0] * s2_alpha_ff[ALPHA_LO-1:0];
      s3_eplo_in = s2_e2_ff * s2_pt2_ff[PT2_LO-1:0];
      s3_ephi_in = s2_e2_ff * s2_pt2_ff[PT2_W-1:PT2_LO];
   end

   always_ff @(posedge clock) begin
      s3_blo_ff  <= s3_blo_in;
      s3_bhi_ff  <= s3_bhi_in;
      s3_aahh_ff <= s3_aahh_in;
      s3_aahl_ff <= s3_aahl_in;
      s3_aall_ff <= s3_aall_in;
      s3_eplo_ff <= s3_eplo_in;
      s3_ephi_ff <= s3_ephi_in;
      s3_a_ff    <= s2_a_ff;
   end

   // stage 4: sum partials
   always_comb begin
      s4_b_in   = (s3_bhi_ff <<< ALPHA_LO) + s3_blo_ff;
      s4_al2_in = (s3_aahh_ff <<< (2 * ALPHA_LO)) + (s3_aahl_ff <<< (ALPHA_LO + 1))
                  + $signed({1'b0, s3_aall_ff});
      s4_ep_in  = (EP_W'(s3_ephi_ff) << PT2_LO) + EP_W'(s3_eplo_ff);
   end

   always_ff @(posedge clock) begin
      s4_b_ff   <= s4_b_in;
      s4_al2_ff <= s4_al2_in;
      s4_ep_ff  <= s4_ep_in;
      s4_a_ff   <= s3_a_ff;
   end

   // stage 5: 4c
   assign s5_c4_in = s4_al2_ff - $signed({1'b0, s4_ep_ff, 2'b00});

   always_ff @(posedge clock) begin
      s5_c4_ff <= s5_c4_in;
      s5_b_ff  <= s4_b_ff;
      s5_a_ff  <= s4_a_ff;
   end

   // stage 6: partial products of b^2 and a*4c
   always_comb begin
      s6_bbhh_in = $signed(s5_b_ff[B_W-1:B_LO]) * $signed(s5_b_ff[B_W-1:B_LO]);
      s6_bbhl_in = $signed(s5_b_ff[B_W-1:B_LO]) * $signed({1'b0, s5_b_ff[B_LO-1:0]});
      s6_bbll_in = s5_b_ff[B_LO-1:0] * s5_b_ff[B_LO-1:0];
      s6_achh_in = $signed(s5_a_ff[A_W-1:A_LO]) * $signed(s5_c4_ff[C4_W-1:C4_LO]);
      s6_achl_in = $signed(s5_a_ff[A_W-1:A_LO]) * $signed({1'b0, s5_c4_ff[C4_LO-1:0]});
      s6_aclh_in = $signed({1'b0, s5_a_ff[A_LO-1:0]}) * $signed(s5_c4_ff[C4_W-1:C4_LO]);
      s6_acll_in = s5_a_ff[A_LO-1:0] * s5_c4_ff[C4_LO-1:0];
   end

   always_ff @(posedge clock) begin
      s6_bbhh_ff <= s6_bbhh_in;
      s6_bbhl_ff <= s6_bbhl_in;
      s6_bbll_ff <= s6_bbll_in;
      s6_achh_ff <= s6_achh_in;
      s6_achl_ff <= s6_achl_in;
      s6_aclh_ff <= s6_aclh_in;
      s6_acll_ff <= s6_acll_in;
      s6_b_ff    <= s5_b_ff;
      s6_a_ff    <= s5_a_ff;
   end

   // stage 7: b^2 and a*4c
   always_comb begin
      s7_bsq_in = (s6_bbhh_ff <<< (2 * B_LO)) + (s6_bbhl_ff <<< (B_LO + 1))
                  + $signed({1'b0, s6_bbll_ff});
      s7_ac_in  = (s6_achh_ff <<< (A_LO + C4_LO)) + (s6_achl_ff <<< A_LO)
                  + (s6_aclh_ff <<< C4_LO) + $signed({1'b0, s6_acll_ff});
   end

   always_ff @(posedge clock) begin
      s7_bsq_ff <= s7_bsq_in;
      s7_ac_ff  <= s7_ac_in;
      s7_b_ff   <= s6_b_ff;
      s7_a_ff   <= s6_a_ff;
   end

   // stage 8: discriminant and solution count
   always_comb begin
      disc = s7_bsq_ff - s7_ac_ff;
      mid_in.nb         = -s7_b_ff;
      mid_in.den        = {s7_a_ff, 1'b0};
      mid_in.degenerate = s7_a_ff == '0;
      if (mid_in.degenerate || disc[D_W-1]) begin
         mid_in.count = COUNT_NONE;
      end else if (disc == '0) begin
         mid_in.count = COUNT_ONE;
      end else begin
         mid_in.count = COUNT_TWO;
      end
   end

   always_ff @(posedge clock) begin
      sq_rem_ff[0]  <= RAD_W'($unsigned(disc));
      sq_root_ff[0] <= '0;
      sq_mid_ff[0]  <= mid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= vld_ff[7];
      end
   end

   // floor square root, one root bit per stage
   for (genvar i = 0; i < R_W; i++) begin : g_sqrt
      localparam int K = R_W - 1 - i;
      logic [RAD_W-1:0] trial;
      logic             take;
      logic [RAD_W-1:0] rem_in;
      logic [R_W-1:0]   root_in;

      assign trial   = (RAD_W'(sq_root_ff[i]) << (K + 1)) | (ONE_RAD << (2 * K));
      assign take    = sq_rem_ff[i] >= trial;
      assign rem_in  = take ? sq_rem_ff[i] - trial : sq_rem_ff[i];
      assign root_in = sq_root_ff[i] | (R_W'(take) << K);

      always_ff @(posedge clock) begin
         sq_rem_ff[i+1]  <= rem_in;
         sq_root_ff[i+1] <= root_in;
         sq_mid_ff[i+1]  <= sq_mid_ff[i];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[i+1] <= 1'b0;
         end else begin
            sq_vld_ff[i+1] <= sq_vld_ff[i];
         end
      end
   end

   // numerators -b + r and -b - r
   always_comb begin
      num_n_in[0] = sq_mid_ff[R_W].nb + $signed({1'b0, sq_root_ff[R_W]});
      num_n_in[1] = sq_mid_ff[R_W].nb - $signed({1'b0, sq_root_ff[R_W]});
   end

   always_ff @(posedge clock) begin
      num_n_ff[0] <= num_n_in[0];
      num_n_ff[1] <= num_n_in[1];
      num_mid_ff  <= sq_mid_ff[R_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vld_ff <= 1'b0;
      end else begin
         num_vld_ff <= sq_vld_ff[R_W];
      end
   end

   // divider setup: magnitudes, sign, saturation
   assign den_mag = num_mid_ff.den[DEN_W-1] ? $unsigned(-num_mid_ff.den)
                                            : $unsigned(num_mid_ff.den);

   for (genvar l = 0; l < 2; l++) begin : g_prep
      assign n_mag[l] = num_n_ff[l][N_W-1] ? $unsigned(-num_n_ff[l]) : $unsigned(num_n_ff[l]);

      always_ff @(posedge clock) begin
         dv_rem_ff[0][l] <= DIV_W'(n_mag[l]);
         dv_q_ff[0][l]   <= '0;
         dv_neg_ff[0][l] <= num_n_ff[l][N_W-1] ^ num_mid_ff.den[DEN_W-1];
         dv_sat_ff[0][l] <= DIV_W'(n_mag[l]) >= (DIV_W'(den_mag) << Q_W);
      end
   end

   always_ff @(posedge clock) begin
      dv_dmag_ff[0] <= den_mag;
      dv_cnt_ff[0]  <= num_mid_ff.count;
      dv_deg_ff[0]  <= num_mid_ff.degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= num_vld_ff;
      end
   end

   // restoring division, one quotient bit per stage, two lanes
   for (genvar j = 0; j < Q_W; j++) begin : g_div
      localparam int K = Q_W - 1 - j;
      logic [DIV_W-1:0] sub;

      assign sub = DIV_W'(dv_dmag_ff[j]) << K;

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic take;
         assign take = dv_rem_ff[j][l] >= sub;

         always_ff @(posedge clock) begin
            dv_rem_ff[j+1][l] <= take ? dv_rem_ff[j][l] - sub : dv_rem_ff[j][l];
            dv_q_ff[j+1][l]   <= dv_q_ff[j][l] | (Q_W'(take) << K);
            dv_neg_ff[j+1][l] <= dv_neg_ff[j][l];
            dv_sat_ff[j+1][l] <= dv_sat_ff[j][l];
         end
      end

      always_ff @(posedge clock) begin
         dv_dmag_ff[j+1] <= dv_dmag_ff[j];
         dv_cnt_ff[j+1]  <= dv_cnt_ff[j];
         dv_deg_ff[j+1]  <= dv_deg_ff[j];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
      end
   end

   // result formatting
   for (genvar l = 0; l < 2; l++) begin : g_out
      always_comb begin
         if (dv_sat_ff[Q_W][l]) begin
            lane_val[l] = dv_neg_ff[Q_W][l] ? PZ_MIN : PZ_MAX;
         end else if (dv_neg_ff[Q_W][l]) begin
            lane_val[l] = -$signed({1'b0, dv_q_ff[Q_W][l]});
         end else begin
            lane_val[l] = $signed({1'b0, dv_q_ff[Q_W][l]});
         end
      end
   end

   always_comb begin
      rsp_in.solution_count = dv_cnt_ff[Q_W];
      rsp_in.degenerate     = dv_deg_ff[Q_W];
      rsp_in.pz_first       = (dv_cnt_ff[Q_W] != COUNT_NONE) ? lane_val[0] : '0;
      rsp_in.pz_second      = (dv_cnt_ff[Q_W] == COUNT_TWO) ? lane_val[1] : '0;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_vld_ff[Q_W];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("start transfer without result after pipeline latency");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && csr_hit) |=> w_mass_ff == $past(pwdata[W_MASS_BITS-1:0]))
      else $error("w_mass write lost");

   a_no_solution: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.solution_count == COUNT_NONE)
      |-> (rsp_data.pz_first == '0 && rsp_data.pz_second == '0))
      else $error("nonzero pz with no solution");
`endif

endmodule
